FILE: hdl/vgn_pkg.sv
// ----------------------------------------------------------------------------
// vgn_pkg: shared types and constants for the volume gradient block
// Controller state, command and status structs, register indexes.
// ----------------------------------------------------------------------------
package vgn_pkg;

  localparam int unsigned DepthLimit = 4096;
  localparam logic [7:0] GradOffset = 8'd127;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegDepth  = 2'd2;
  localparam logic [1:0] RegAlpha  = 2'd3;

  localparam logic [1:0] AlphaNone  = 2'd0;
  localparam logic [1:0] AlphaVoxel = 2'd1;
  localparam logic [1:0] AlphaMag   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_XL,
    ST_RD_XH,
    ST_RD_YL,
    ST_RD_YH,
    ST_RD_ZL,
    ST_RD_MID,
    ST_WRITE,
    ST_SQRT,
    ST_OUT
  } vgn_state_e;

  typedef struct packed {
    logic       clear;     // restart counters
    logic       take;      // latch input item
    logic [2:0] rd_sel;    // neighbor being read
    logic       rd_en;
    logic       rd_cap;    // capture read data of previous read
    logic [2:0] cap_sel;
    logic       wr_en;
    logic       advance;   // bump write/out positions and in_count
    logic       sqrt_start;
    logic       out_load;
  } vgn_cmd_t;

  typedef struct packed {
    logic loading;
    logic emit;
    logic ignore;
    logic sqrt_done;
    logic last;
  } vgn_sts_t;

  localparam logic [2:0] SelXl  = 3'd0;
  localparam logic [2:0] SelXh  = 3'd1;
  localparam logic [2:0] SelYl  = 3'd2;
  localparam logic [2:0] SelYh  = 3'd3;
  localparam logic [2:0] SelZl  = 3'd4;
  localparam logic [2:0] SelMid = 3'd5;

endpackage

FILE: hdl/vgn_ram.sv
// ----------------------------------------------------------------------------
// vgn_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module vgn_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: hdl/vgn_ctrl.sv
// ----------------------------------------------------------------------------
// vgn_ctrl: sequencer for one voxel request
// Walks the neighbor reads, the store write, the square root and the result.
// ----------------------------------------------------------------------------
module vgn_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic              cfg_wr_i,
  input  logic [1:0]        alpha_mode_i,
  input  vgn_pkg::vgn_sts_t sts_i,
  output vgn_pkg::vgn_cmd_t cmd_o
);
  import vgn_pkg::*;

  vgn_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  // input waits after a register write while plane and then volume sizes are registered
  logic       cfg_d1_q, cfg_d2_q;

  // the output register frees once taken; a new request may enter meanwhile
  wire out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (sts_i.ignore) state_d = ST_IDLE;
          else if (sts_i.emit) state_d = ST_RD_XL;
          else state_d = ST_WRITE;
        end
      end
      ST_RD_XL:  state_d = ST_RD_XH;
      ST_RD_XH:  state_d = ST_RD_YL;
      ST_RD_YL:  state_d = ST_RD_YH;
      ST_RD_YH:  state_d = ST_RD_ZL;
      ST_RD_ZL:  state_d = ST_RD_MID;
      ST_RD_MID: state_d = ST_WRITE;
      ST_WRITE:  state_d = (sts_i.emit && alpha_mode_i == AlphaMag) ? ST_SQRT
                         : (sts_i.emit ? ST_OUT : ST_IDLE);
      ST_SQRT:   if (sts_i.sqrt_done) state_d = ST_OUT;
      ST_OUT:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
    if (cfg_wr_i) state_d = ST_IDLE;
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = (state_q == ST_IDLE) && !cfg_wr_i && !cfg_d1_q && !cfg_d2_q;
    cmd_o.clear = cfg_wr_i;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.take = in_valid_i && in_ready_o;
      end
      ST_RD_XL: begin cmd_o.rd_en = 1'b1; cmd_o.rd_sel = SelXl; end
      ST_RD_XH: begin
        cmd_o.rd_en = 1'b1; cmd_o.rd_sel = SelXh;
        cmd_o.rd_cap = 1'b1; cmd_o.cap_sel = SelXl;
      end
      ST_RD_YL: begin
        cmd_o.rd_en = 1'b1; cmd_o.rd_sel = SelYl;
        cmd_o.rd_cap = 1'b1; cmd_o.cap_sel = SelXh;
      end
      ST_RD_YH: begin
        cmd_o.rd_en = 1'b1; cmd_o.rd_sel = SelYh;
        cmd_o.rd_cap = 1'b1; cmd_o.cap_sel = SelYl;
      end
      ST_RD_ZL: begin
        cmd_o.rd_en = 1'b1; cmd_o.rd_sel = SelZl;
        cmd_o.rd_cap = 1'b1; cmd_o.cap_sel = SelYh;
      end
      ST_RD_MID: begin
        cmd_o.rd_en = 1'b1; cmd_o.rd_sel = SelMid;
        cmd_o.rd_cap = 1'b1; cmd_o.cap_sel = SelZl;
      end
      ST_WRITE: begin
        cmd_o.rd_cap = sts_i.emit; cmd_o.cap_sel = SelMid;
        cmd_o.wr_en = sts_i.loading;
        cmd_o.advance = 1'b1;
        cmd_o.sqrt_start = sts_i.emit && alpha_mode_i == AlphaMag;
      end
      ST_SQRT: ;
      ST_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
      cfg_d1_q <= 1'b0;
      cfg_d2_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      cfg_d1_q <= cfg_wr_i;
      cfg_d2_q <= cfg_d1_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take |-> state_q == ST_IDLE) else $error("take outside idle");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> out_free) else $error("result overwritten");
  a_sqrt_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SQRT |-> alpha_mode_i == AlphaMag) else $error("sqrt in wrong mode");
`endif
endmodule

FILE: hdl/vgn_dp.sv
// ----------------------------------------------------------------------------
// vgn_dp: gradient datapath
// Position counters, window store, differences and bit-serial square root.
// ----------------------------------------------------------------------------
module vgn_dp #(
  parameter int unsigned MaxWidth  = 256,
  parameter int unsigned MaxHeight = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vgn_pkg::vgn_cmd_t cmd_i,
  output vgn_pkg::vgn_sts_t sts_o,
  input  logic [8:0]        vol_width_i,
  input  logic [8:0]        vol_height_i,
  input  logic [12:0]       vol_depth_i,
  input  logic [1:0]        alpha_mode_i,
  input  logic              in_drain_i,
  input  logic [7:0]        in_voxel_i,
  output logic [7:0]        grad_x_o,
  output logic [7:0]        grad_y_o,
  output logic [7:0]        grad_z_o,
  output logic [7:0]        alpha_out_o,
  output logic              last_voxel_o
);
  import vgn_pkg::*;

  localparam int unsigned XW = $clog2(MaxWidth);
  localparam int unsigned YW = $clog2(MaxHeight);
  localparam int unsigned AW = 1 + XW + YW;
  localparam int unsigned PW = XW + YW + 1;      // plane size bits
  localparam int unsigned TW = PW + 13;          // total count bits

  // clamped geometry
  logic [XW:0] w;
  logic [YW:0] h;
  logic [12:0] d;
  always_comb begin
    if (vol_width_i == '0) w = (XW+1)'(1);
    else if ({{(XW+1){1'b0}}, vol_width_i} > (XW+10)'(MaxWidth)) w = (XW+1)'(MaxWidth);
    else w = (XW+1)'(vol_width_i);
    if (vol_height_i == '0) h = (YW+1)'(1);
    else if ({{(YW+1){1'b0}}, vol_height_i} > (YW+10)'(MaxHeight)) h = (YW+1)'(MaxHeight);
    else h = (YW+1)'(vol_height_i);
    if (vol_depth_i == '0) d = 13'd1;
    else if (vol_depth_i > 13'(DepthLimit)) d = 13'(DepthLimit);
    else d = vol_depth_i;
  end

  // plane/total sizes registered; geometry only changes while idle, by user (unchecked)
  logic [PW-1:0] plane_q, plane_d;
  logic [TW-1:0] total_q, total_d;
  assign plane_d = PW'(w) * PW'(h);
  assign total_d = TW'(plane_q) * TW'(d);
  always_ff @(posedge clk_i) begin
    plane_q <= plane_d;
    total_q <= total_d;
  end

  logic [TW-1:0] in_cnt_q;
  logic [XW-1:0] wx_q, ox_q;
  logic [YW-1:0] wy_q, oy_q;
  logic          wz_q;
  logic [12:0]   oz_q;
  logic [7:0]    cur_q;

  wire loading = in_cnt_q < total_q;
  wire emit    = in_cnt_q >= TW'(plane_q);
  assign sts_o.loading = loading;
  assign sts_o.emit    = emit;
  assign sts_o.ignore  = loading && in_drain_i;

  wire ox_end = (XW+1)'(ox_q) == w - 1'b1;
  wire oy_end = (YW+1)'(oy_q) == h - 1'b1;
  wire oz_end = oz_q == d - 1'b1;
  wire fin    = ox_end && oy_end && oz_end;
  assign sts_o.last = fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q <= '0; wx_q <= '0; wy_q <= '0; wz_q <= 1'b0;
      ox_q <= '0; oy_q <= '0; oz_q <= '0;
    end else if (cmd_i.clear || (cmd_i.advance && emit && fin)) begin
      in_cnt_q <= '0; wx_q <= '0; wy_q <= '0; wz_q <= 1'b0;
      ox_q <= '0; oy_q <= '0; oz_q <= '0;
    end else if (cmd_i.advance) begin
      in_cnt_q <= in_cnt_q + 1'b1;
      if (loading) begin
        if ((XW+1)'(wx_q) == w - 1'b1) begin
          wx_q <= '0;
          if ((YW+1)'(wy_q) == h - 1'b1) begin
            wy_q <= '0; wz_q <= ~wz_q;
          end else wy_q <= wy_q + 1'b1;
        end else wx_q <= wx_q + 1'b1;
      end
      if (emit) begin
        if (ox_end) begin
          ox_q <= '0;
          if (oy_end) begin oy_q <= '0; oz_q <= oz_q + 1'b1; end
          else oy_q <= oy_q + 1'b1;
        end else ox_q <= ox_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      cur_q <= in_voxel_i;
    end
  end

  // store address
  logic [AW-1:0] addr;
  logic [XW-1:0] ax;
  logic [YW-1:0] ay;
  logic          az;
  always_comb begin
    ax = ox_q; ay = oy_q; az = oz_q[0];
    unique case (cmd_i.rd_sel)
      SelXl:  ax = ox_q - 1'b1;
      SelXh:  ax = ox_q + 1'b1;
      SelYl:  ay = oy_q - 1'b1;
      SelYh:  ay = oy_q + 1'b1;
      SelZl:  az = ~oz_q[0];
      default: ;
    endcase
    if (cmd_i.wr_en) begin
      ax = wx_q; ay = wy_q; az = wz_q;
    end
    addr = {az, ay, ax};
  end

  logic [7:0] rdata;
  vgn_ram #(.Width(8), .Depth(1 << AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .addr_i  (addr),
    .wdata_i (cur_q),
    .rdata_o (rdata)
  );

  // captured neighbors, zero beyond borders; the upper z neighbor is the request itself
  logic [7:0] xl_q, xh_q, yl_q, yh_q, zl_q, zh_q, mid_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_cap) begin
      unique case (cmd_i.cap_sel)
        SelXl:  xl_q  <= (ox_q != '0) ? rdata : 8'd0;
        SelXh:  xh_q  <= !ox_end ? rdata : 8'd0;
        SelYl:  yl_q  <= (oy_q != '0) ? rdata : 8'd0;
        SelYh:  yh_q  <= !oy_end ? rdata : 8'd0;
        SelZl: begin
          zl_q <= (oz_q != '0) ? rdata : 8'd0;
          zh_q <= oz_end ? 8'd0 : cur_q;
        end
        default: mid_q <= rdata;
      endcase
    end
  end

  logic signed [8:0] dx, dy, dz;
  assign dx = $signed({1'b0, xl_q}) - $signed({1'b0, xh_q});
  assign dy = $signed({1'b0, yl_q}) - $signed({1'b0, yh_q});
  assign dz = $signed({1'b0, zl_q}) - $signed({1'b0, zh_q});

  function automatic logic [7:0] half_off(input logic signed [8:0] v);
    logic signed [8:0] hv;
    hv = (v < 0) ? -((-v) >>> 1) : (v >>> 1);
    return 8'(hv + 9'sd127);
  endfunction

  function automatic logic [17:0] sq9(input logic signed [8:0] v);
    logic signed [17:0] e;
    e = v;
    return 18'(e * e);
  endfunction

  // sum of squares over 3: reciprocal multiply, exact over the full range
  logic [17:0] ssq_q;
  logic [16:0] quo;
  logic [35:0] prod;
  always_ff @(posedge clk_i) begin
    if (cmd_i.advance) begin
      ssq_q <= sq9(dx) + sq9(dy) + sq9(dz);
    end
  end
  assign prod = {18'd0, ssq_q} * 36'd174763;
  assign quo  = 17'(prod >> 19);

  // bit-serial square root, two result bits per step pair
  logic [16:0] sv_q, sr_q, sb_q;
  logic        sbusy_q, sload_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbusy_q <= 1'b0; sload_q <= 1'b0;
    end else begin
      sload_q <= cmd_i.sqrt_start;
      if (sload_q) sbusy_q <= 1'b1;
      else if (sbusy_q && sb_q == '0) sbusy_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (sload_q) begin
      sv_q <= quo; sr_q <= '0; sb_q <= 17'h10000;
    end else if (sbusy_q && sb_q != '0) begin
      if (sv_q >= sr_q + sb_q) begin
        sv_q <= sv_q - (sr_q + sb_q);
        sr_q <= (sr_q >> 1) + sb_q;
      end else sr_q <= sr_q >> 1;
      sb_q <= sb_q >> 2;
    end
  end
  assign sts_o.sqrt_done = sbusy_q && sb_q == '0;

  logic lastf_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.advance) lastf_q <= emit && fin;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      grad_x_o <= half_off(dx);
      grad_y_o <= half_off(dy);
      grad_z_o <= half_off(dz);
      unique case (alpha_mode_i)
        AlphaVoxel: alpha_out_o <= mid_q;
        AlphaMag:   alpha_out_o <= (sr_q > 17'd255) ? 8'd255 : sr_q[7:0];
        default:    alpha_out_o <= 8'd0;
      endcase
      last_voxel_o <= lastf_q;
    end
  end

`ifndef ASSERT_OFF
  a_wr_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> loading) else $error("write after load");
  a_sqrt_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.sqrt_done |-> sr_q < 17'd256) else $error("root overflow");
  a_no_rd_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.rd_en && cmd_i.wr_en)) else $error("port conflict");
`endif
endmodule

FILE: hdl/volume_gradient_normals.sv
// ----------------------------------------------------------------------------
// volume_gradient_normals: 3D central-difference gradient of a voxel stream
//
//   channel | handshake             | payload
//   in      | in_valid_i/in_ready_o | voxel_i, drain_i
//   out     | out_valid_o/out_ready_i | grad_x/y/z_o, alpha_out_o, last_voxel_o
//   cfg     | APB psel/penable      | paddr, pwdata, prdata
//
// A voxel with a result is accepted, then takes six reads and one write (when
// loading) on the single window store port, a square root with magnitude alpha
// (load, nine steps, done) and a result load. A voxel with no result is accepted
// and written, an ignored drain only accepted. A register write holds input off.
// Reset is asynchronous; the window store needs no clearing. The output
// register lets the next request start while a result waits.
// ----------------------------------------------------------------------------
module volume_gradient_normals #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  voxel_i,
  input  logic        drain_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  grad_x_o,
  output logic [7:0]  grad_y_o,
  output logic [7:0]  grad_z_o,
  output logic [7:0]  alpha_out_o,
  output logic        last_voxel_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vgn_pkg::*;

  logic [8:0]  vol_width_q, vol_height_q;
  logic [12:0] vol_depth_q;
  logic [1:0]  alpha_mode_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_width_q <= 9'd256; vol_height_q <= 9'd256;
      vol_depth_q <= 13'd1;  alpha_mode_q <= AlphaNone;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegWidth:  vol_width_q  <= pwdata[8:0];
        RegHeight: vol_height_q <= pwdata[8:0];
        RegDepth:  vol_depth_q  <= pwdata[12:0];
        default:   alpha_mode_q <= pwdata[1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegWidth:  prdata = {23'd0, vol_width_q};
      RegHeight: prdata = {23'd0, vol_height_q};
      RegDepth:  prdata = {19'd0, vol_depth_q};
      default:   prdata = {30'd0, alpha_mode_q};
    endcase
  end

  vgn_cmd_t cmd;
  vgn_sts_t sts;

  vgn_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cfg_wr_i (cfg_wr), .alpha_mode_i (alpha_mode_q),
    .sts_i (sts), .cmd_o (cmd)
  );

  vgn_dp #(.MaxWidth(MAX_WIDTH), .MaxHeight(MAX_HEIGHT)) u_dp (
    .clk_i, .rst_ni, .cmd_i (cmd), .sts_o (sts),
    .vol_width_i (vol_width_q), .vol_height_i (vol_height_q),
    .vol_depth_i (vol_depth_q), .alpha_mode_i (alpha_mode_q),
    .in_drain_i (drain_i), .in_voxel_i (voxel_i),
    .grad_x_o, .grad_y_o, .grad_z_o, .alpha_out_o, .last_voxel_o
  );
endmodule
